// ===== rtl/twtls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtls_pkg
// Shared types, constants and helper functions for the two-way traffic light
// sequencer.
// ----------------------------------------------------------------------------
package twtls_pkg;

  localparam int unsigned TicksPerSecondDefault = 100;
  localparam int unsigned ScanTicksDefault      = 25;
  localparam int unsigned DigitCount            = 4;

  localparam int unsigned SecW   = 7;
  localparam int unsigned LampW  = 2;
  localparam int unsigned DigitW = 4;
  localparam int unsigned SelW   = $clog2(DigitCount);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SecW-1:0] MaxSeconds = SecW'(99);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RED    = 2'd0,
    CFG_GREEN  = 2'd1,
    CFG_YELLOW = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_RG     = 3'd1,
    PH_RY     = 3'd2,
    PH_GR     = 3'd3,
    PH_YR     = 3'd4,
    PH_MANUAL = 3'd5
  } phase_e;

  typedef enum logic [LampW-1:0] {
    LAMP_OFF    = 2'd0,
    LAMP_RED    = 2'd1,
    LAMP_YELLOW = 2'd2,
    LAMP_GREEN  = 2'd3
  } lamp_e;

  typedef struct packed {
    logic [LampW-1:0]  lamp_first;
    logic [LampW-1:0]  lamp_second;
    logic [SecW-1:0]   count_first;
    logic [SecW-1:0]   count_second;
    logic [SelW-1:0]   digit_select;
    logic [DigitW-1:0] digit_value;
    logic              manual_mode;
  } result_t;

  // Values above 99 saturate at 99.
  function automatic logic [SecW-1:0] clamp99(input logic [SecW-1:0] v);
    return (v > MaxSeconds) ? MaxSeconds : v;
  endfunction

  // Tens digit of a value up to 99, by multiplying with 103/1024.
  function automatic logic [DigitW-1:0] tens_of(input logic [SecW-1:0] v);
    logic [13:0] prod;
    prod = 14'(v) * 14'd103;
    return prod[13:10];
  endfunction

  function automatic logic [DigitW-1:0] units_of(input logic [SecW-1:0] v);
    logic [SecW-1:0] t;
    t = SecW'(tens_of(v));
    return DigitW'(v - SecW'(t * SecW'(10)));
  endfunction

endpackage

// ===== rtl/twtls_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtls_core
// Phase sequencer, second counters and digit scanner. State advances by one
// tick on every accepted word and the matching result is produced alongside.
// ----------------------------------------------------------------------------
module twtls_core #(
  parameter int unsigned TICKS_PER_SECOND = twtls_pkg::TicksPerSecondDefault,
  parameter int unsigned SCAN_TICKS       = twtls_pkg::ScanTicksDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       mode_press_i,
  input  logic [twtls_pkg::SecW-1:0] red_seconds_i,
  input  logic [twtls_pkg::SecW-1:0] green_seconds_i,
  input  logic [twtls_pkg::SecW-1:0] yellow_seconds_i,
  output twtls_pkg::result_t         result_o
);
  import twtls_pkg::*;

  localparam int unsigned TpsW  = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned PtW   = $clog2(99 * TICKS_PER_SECOND + 1);
  localparam int unsigned ScanW = $clog2(SCAN_TICKS + 1);

  phase_e              phase_q, phase_d;
  logic [SecW-1:0]     first_q, first_d, second_q, second_d;
  logic [PtW-1:0]      phase_ticks_q, phase_ticks_d;
  logic [TpsW-1:0]     sec_ticks_q, sec_ticks_d;
  logic [ScanW-1:0]    scan_ticks_q, scan_ticks_d;
  logic [SelW-1:0]     scan_idx_q, scan_idx_d;
  logic [SelW-1:0]     shown_q, shown_d;
  logic [DigitW-1:0]   digit_q, digit_d;

  logic                running;
  logic [SecW-1:0]     phase_secs;
  logic [PtW-1:0]      limit;
  logic [SecW-1:0]     scan_src;
  logic [LampW-1:0]    lamp_first, lamp_second;

  assign running = (phase_q == PH_RG) || (phase_q == PH_RY) ||
                   (phase_q == PH_GR) || (phase_q == PH_YR);

  assign phase_secs = ((phase_q == PH_RG) || (phase_q == PH_GR)) ?
                      clamp99(green_seconds_i) : clamp99(yellow_seconds_i);
  assign limit = PtW'(phase_secs) * PtW'(TICKS_PER_SECOND);

  // Next state of the sequencer and its counters.
  always_comb begin
    logic [TpsW-1:0] st;
    logic [PtW-1:0]  pt;
    phase_d       = phase_q;
    first_d       = first_q;
    second_d      = second_q;
    phase_ticks_d = phase_ticks_q;
    sec_ticks_d   = sec_ticks_q;
    st            = sec_ticks_q + TpsW'(1);
    pt            = phase_ticks_q + PtW'(1);
    if (phase_q == PH_INIT) begin
      phase_d       = PH_RG;
      first_d       = clamp99(red_seconds_i);
      second_d      = clamp99(green_seconds_i);
      phase_ticks_d = '0;
      sec_ticks_d   = '0;
    end else if (running) begin
      sec_ticks_d = st;
      if (st >= TpsW'(TICKS_PER_SECOND)) begin
        sec_ticks_d = '0;
        if (first_q != '0) first_d = first_q - SecW'(1);
        if (second_q != '0) second_d = second_q - SecW'(1);
      end
      phase_ticks_d = pt;
      if (pt >= limit) begin
        phase_ticks_d = '0;
        unique case (phase_q)
          PH_RG: begin
            phase_d  = PH_RY;
            first_d  = clamp99(yellow_seconds_i);
            second_d = clamp99(yellow_seconds_i);
          end
          PH_RY: begin
            phase_d  = PH_GR;
            first_d  = clamp99(green_seconds_i);
            second_d = clamp99(red_seconds_i);
          end
          PH_GR: begin
            phase_d  = PH_YR;
            first_d  = clamp99(yellow_seconds_i);
            second_d = clamp99(yellow_seconds_i);
          end
          default: begin
            phase_d  = PH_RG;
            first_d  = clamp99(red_seconds_i);
            second_d = clamp99(green_seconds_i);
          end
        endcase
      end
      if (mode_press_i) phase_d = PH_MANUAL;
    end
  end

  // Digit scanner, fed by the counters after this tick.
  assign scan_src = (scan_idx_q < SelW'(2)) ? first_d : second_d;

  always_comb begin
    logic [ScanW-1:0] sc;
    scan_ticks_d = scan_ticks_q;
    scan_idx_d   = scan_idx_q;
    shown_d      = shown_q;
    digit_d      = digit_q;
    sc           = scan_ticks_q + ScanW'(1);
    if (phase_q == PH_INIT) begin
      scan_ticks_d = '0;
    end else if (sc >= ScanW'(SCAN_TICKS)) begin
      scan_ticks_d = '0;
      shown_d      = scan_idx_q;
      scan_idx_d   = scan_idx_q + SelW'(1);
      digit_d      = scan_idx_q[0] ? units_of(scan_src) : tens_of(scan_src);
    end else begin
      scan_ticks_d = sc;
    end
  end

  // Lamp outputs for the phase handled in this tick.
  always_comb begin
    lamp_first  = LAMP_OFF;
    lamp_second = LAMP_OFF;
    if (!mode_press_i) begin
      unique case (phase_q)
        PH_RG: begin
          lamp_first  = LAMP_RED;
          lamp_second = LAMP_GREEN;
        end
        PH_RY: begin
          lamp_first  = LAMP_RED;
          lamp_second = LAMP_YELLOW;
        end
        PH_GR: begin
          lamp_first  = LAMP_GREEN;
          lamp_second = LAMP_RED;
        end
        PH_YR: begin
          lamp_first  = LAMP_YELLOW;
          lamp_second = LAMP_RED;
        end
        default: begin
          lamp_first  = LAMP_OFF;
          lamp_second = LAMP_OFF;
        end
      endcase
    end
  end

  always_comb begin
    result_o.lamp_first   = lamp_first;
    result_o.lamp_second  = lamp_second;
    result_o.count_first  = first_d;
    result_o.count_second = second_d;
    result_o.digit_select = shown_d;
    result_o.digit_value  = digit_d;
    result_o.manual_mode  = (phase_d != PH_INIT) && (phase_d != PH_RG) &&
                            (phase_d != PH_RY) && (phase_d != PH_GR) &&
                            (phase_d != PH_YR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_INIT;
      first_q       <= '0;
      second_q      <= '0;
      phase_ticks_q <= '0;
      sec_ticks_q   <= '0;
      scan_ticks_q  <= '0;
      scan_idx_q    <= '0;
      shown_q       <= '0;
      digit_q       <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      first_q       <= first_d;
      second_q      <= second_d;
      phase_ticks_q <= phase_ticks_d;
      sec_ticks_q   <= sec_ticks_d;
      scan_ticks_q  <= scan_ticks_d;
      scan_idx_q    <= scan_idx_d;
      shown_q       <= shown_d;
      digit_q       <= digit_d;
    end
  end

endmodule

// ===== rtl/twtls_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtls_skid
// Two-entry output register for result words, so that a new word can be
// taken while the previous one waits downstream.
// ----------------------------------------------------------------------------
module twtls_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  twtls_pkg::result_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output twtls_pkg::result_t out_data_o
);
  import twtls_pkg::*;

  result_t main_q, skid_q;
  logic    main_valid_q, skid_valid_q;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !main_valid_q) begin
      main_valid_q <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !main_valid_q) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule

// ===== rtl/two_way_traffic_light_sequencer.sv =====
`timescale 1ns / 1ps
// A result word is registered at the edge that accepts its tick word.
// Throughput: one tick word per cycle while the output register has room; the state update is a single pass of
// short logic between the state registers and a two-entry output register.
// Reset: asynchronous, active low; the sequencer returns to its init phase
// and the duration registers return to red 5, green 3 and yellow 2 seconds.
// ----------------------------------------------------------------------------
// two_way_traffic_light_sequencer
// Two-direction traffic light controller advanced by one 10 ms tick per input
// word, with per-direction countdowns and a scanned four-digit display.
// ----------------------------------------------------------------------------
module two_way_traffic_light_sequencer #(
  parameter int unsigned TICKS_PER_SECOND = twtls_pkg::TicksPerSecondDefault,
  parameter int unsigned SCAN_TICKS       = twtls_pkg::ScanTicksDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [twtls_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [twtls_pkg::SecW-1:0]    cfg_data_i,
  // Tick words.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_press_i,
  // Result words.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [twtls_pkg::LampW-1:0]   lamp_first_o,
  output logic [twtls_pkg::LampW-1:0]   lamp_second_o,
  output logic [twtls_pkg::SecW-1:0]    count_first_o,
  output logic [twtls_pkg::SecW-1:0]    count_second_o,
  output logic [twtls_pkg::SelW-1:0]    digit_select_o,
  output logic [twtls_pkg::DigitW-1:0]  digit_value_o,
  output logic                          manual_mode_o
);
  import twtls_pkg::*;

  logic [SecW-1:0] red_q, green_q, yellow_q;
  logic            step;
  result_t         core_result, out_result;

  // The duration registers hold the raw written values; the core saturates
  // them at 99 where they are used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q    <= SecW'(5);
      green_q  <= SecW'(3);
      yellow_q <= SecW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RED:    red_q    <= cfg_data_i;
        CFG_GREEN:  green_q  <= cfg_data_i;
        CFG_YELLOW: yellow_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // A tick word advances the sequencer in the cycle it is accepted, and its
  // result word is captured in the output register at the same edge.
  assign step = in_valid_i && in_ready_o;

  twtls_core #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .SCAN_TICKS      (SCAN_TICKS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .mode_press_i    (mode_press_i),
    .red_seconds_i   (red_q),
    .green_seconds_i (green_q),
    .yellow_seconds_i(yellow_q),
    .result_o        (core_result)
  );

  // The skid entry lets a new tick be taken while a result is still waiting.
  twtls_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (core_result),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_result)
  );

  assign lamp_first_o   = out_result.lamp_first;
  assign lamp_second_o  = out_result.lamp_second;
  assign count_first_o  = out_result.count_first;
  assign count_second_o = out_result.count_second;
  assign digit_select_o = out_result.digit_select;
  assign digit_value_o  = out_result.digit_value;
  assign manual_mode_o  = out_result.manual_mode;

endmodule

// ===== test/traffic_light_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_light_checker
// Watches the tick and result channels of the traffic light sequencer. It
// keeps its own copy of the phase, counter and display state, works out the
// result word for every accepted tick and compares each result word that
// comes out against the oldest one still waiting.
// ----------------------------------------------------------------------------
module traffic_light_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [twtls_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [twtls_pkg::SecW-1:0]    cfg_data_i,
  input  logic                          tick_valid_i,
  input  logic                          tick_ready_i,
  input  logic                          mode_press_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [twtls_pkg::LampW-1:0]   lamp_first_i,
  input  logic [twtls_pkg::LampW-1:0]   lamp_second_i,
  input  logic [twtls_pkg::SecW-1:0]    count_first_i,
  input  logic [twtls_pkg::SecW-1:0]    count_second_i,
  input  logic [twtls_pkg::SelW-1:0]    digit_select_i,
  input  logic [twtls_pkg::DigitW-1:0]  digit_value_i,
  input  logic                          manual_mode_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   ticks_left_o
);
  import twtls_pkg::*;

  localparam int unsigned TicksPerSec = TicksPerSecondDefault;
  localparam int unsigned ScanPeriod  = ScanTicksDefault;

  logic [SecW-1:0]   red_secs, green_secs, yellow_secs;
  phase_e            phase;
  logic [SecW-1:0]   first_cnt, second_cnt;
  int unsigned       phase_ticks, sec_ticks, scan_ticks;
  logic [SelW-1:0]   scan_idx, shown_idx;
  logic [DigitW-1:0] digit_buf [DigitCount];
  result_t           expected_words[$];
  int unsigned       mismatches;

  function automatic logic [SecW-1:0] cap_seconds(input logic [SecW-1:0] s);
    if (s > MaxSeconds) return MaxSeconds;
    return s;
  endfunction

  function automatic logic is_running(input phase_e p);
    return (p >= PH_RG) && (p <= PH_YR);
  endfunction

  // Length of the current phase in ticks.
  function automatic int unsigned phase_length();
    logic [SecW-1:0] secs;
    secs = (phase == PH_RG || phase == PH_GR) ? green_secs : yellow_secs;
    return int'(cap_seconds(secs)) * TicksPerSec;
  endfunction

  task automatic start_phase(input phase_e nxt, input logic [SecW-1:0] f,
                             input logic [SecW-1:0] s);
    phase       = nxt;
    first_cnt   = cap_seconds(f);
    second_cnt  = cap_seconds(s);
    phase_ticks = 0;
  endtask

  task automatic predict_tick(input logic press, output result_t word);
    lamp_e lf;
    lamp_e ls;
    lf = LAMP_OFF;
    ls = LAMP_OFF;
    if (phase == PH_INIT) begin
      // The first tick only loads the counters; a press here is ignored and
      // no digit is scanned.
      start_phase(PH_RG, red_secs, green_secs);
      sec_ticks  = 0;
      scan_ticks = 0;
    end else begin
      if (is_running(phase)) begin
        case (phase)
          PH_RG: begin
            lf = LAMP_RED;
            ls = LAMP_GREEN;
          end
          PH_RY: begin
            lf = LAMP_RED;
            ls = LAMP_YELLOW;
          end
          PH_GR: begin
            lf = LAMP_GREEN;
            ls = LAMP_RED;
          end
          default: begin
            lf = LAMP_YELLOW;
            ls = LAMP_RED;
          end
        endcase
        // The second boundary is counted before a phase change reloads.
        sec_ticks++;
        if (sec_ticks >= TicksPerSec) begin
          sec_ticks = 0;
          if (first_cnt != '0) first_cnt = first_cnt - 1'b1;
          if (second_cnt != '0) second_cnt = second_cnt - 1'b1;
        end
        phase_ticks++;
        if (phase_ticks >= phase_length()) begin
          case (phase)
            PH_RG:   start_phase(PH_RY, yellow_secs, yellow_secs);
            PH_RY:   start_phase(PH_GR, green_secs, red_secs);
            PH_GR:   start_phase(PH_YR, yellow_secs, yellow_secs);
            default: start_phase(PH_RG, red_secs, green_secs);
          endcase
        end
        // A press wins over a phase change but keeps the reloaded counters.
        if (press) begin
          phase = PH_MANUAL;
          lf    = LAMP_OFF;
          ls    = LAMP_OFF;
        end
      end
      scan_ticks++;
      if (scan_ticks >= ScanPeriod) begin
        scan_ticks   = 0;
        digit_buf[0] = DigitW'(first_cnt / 10);
        digit_buf[1] = DigitW'(first_cnt % 10);
        digit_buf[2] = DigitW'(second_cnt / 10);
        digit_buf[3] = DigitW'(second_cnt % 10);
        shown_idx    = scan_idx;
        scan_idx     = scan_idx + 1'b1;
      end
    end
    word.lamp_first   = lf;
    word.lamp_second  = ls;
    word.count_first  = first_cnt;
    word.count_second = second_cnt;
    word.digit_select = shown_idx;
    word.digit_value  = digit_buf[shown_idx];
    word.manual_mode  = (phase != PH_INIT) && !is_running(phase);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      red_secs    = 7'd5;
      green_secs  = 7'd3;
      yellow_secs = 7'd2;
      phase       = PH_INIT;
      first_cnt   = '0;
      second_cnt  = '0;
      phase_ticks = 0;
      sec_ticks   = 0;
      scan_ticks  = 0;
      scan_idx    = '0;
      shown_idx   = '0;
      foreach (digit_buf[i]) digit_buf[i] = '0;
      expected_words.delete();
      mismatches  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RED:    red_secs = cfg_data_i;
          CFG_GREEN:  green_secs = cfg_data_i;
          CFG_YELLOW: yellow_secs = cfg_data_i;
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) begin
        predict_tick(mode_press_i, want);
        expected_words.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $error("result word arrived with no tick waiting for it");
        end else begin
          want = expected_words.pop_front();
          check_field("lamp_first", 32'(want.lamp_first), 32'(lamp_first_i));
          check_field("lamp_second", 32'(want.lamp_second), 32'(lamp_second_i));
          check_field("count_first", 32'(want.count_first), 32'(count_first_i));
          check_field("count_second", 32'(want.count_second), 32'(count_second_i));
          check_field("digit_select", 32'(want.digit_select), 32'(digit_select_i));
          check_field("digit_value", 32'(want.digit_value), 32'(digit_value_i));
          check_field("manual_mode", 32'(want.manual_mode), 32'(manual_mode_i));
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_words.size();
    if (is_running(phase)) begin
      ticks_left_o <= (phase_length() > phase_ticks) ? phase_length() - phase_ticks : 1;
    end else begin
      ticks_left_o <= 0;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives tick words into the two-way traffic light sequencer under changing
// durations and handshake pressure, and reports the verdict. Prediction and
// comparison live in the checker instantiated next to the block.
// ----------------------------------------------------------------------------
module tb;
  import twtls_pkg::*;

  // The random part is split into segments; each segment gets its own set of
  // durations and one of four idling patterns.
  localparam int unsigned RandomItems  = 480;
  localparam int unsigned SegmentCount = 8;
  localparam int unsigned ManualItems  = 60;
  // The block registers each result word as its tick is accepted; the extra
  // slack makes sure nothing is still in flight.
  localparam int unsigned DrainSlack   = 4;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned EndWaitLimit = 5000;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i    = CFG_RED;
  logic [SecW-1:0]    cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               mode_press_i = 1'b0;
  logic               out_ready_i  = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [LampW-1:0]   lamp_first_o;
  logic [LampW-1:0]   lamp_second_o;
  logic [SecW-1:0]    count_first_o;
  logic [SecW-1:0]    count_second_o;
  logic [SelW-1:0]    digit_select_o;
  logic [DigitW-1:0]  digit_value_o;
  logic               manual_mode_o;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned ticks_left;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  // Each bump of hold_requests asks the receiver for one long hold-off.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  always #1 clk_i = ~clk_i;

  two_way_traffic_light_sequencer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_press_i   (mode_press_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .lamp_first_o   (lamp_first_o),
    .lamp_second_o  (lamp_second_o),
    .count_first_o  (count_first_o),
    .count_second_o (count_second_o),
    .digit_select_o (digit_select_o),
    .digit_value_o  (digit_value_o),
    .manual_mode_o  (manual_mode_o)
  );

  traffic_light_checker u_sequence_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .tick_valid_i     (in_valid_i),
    .tick_ready_i     (in_ready_o),
    .mode_press_i     (mode_press_i),
    .res_valid_i      (out_valid_o),
    .res_ready_i      (out_ready_i),
    .lamp_first_i     (lamp_first_o),
    .lamp_second_i    (lamp_second_o),
    .count_first_i    (count_first_o),
    .count_second_i   (count_second_o),
    .digit_select_i   (digit_select_o),
    .digit_value_i    (digit_value_o),
    .manual_mode_i    (manual_mode_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .ticks_left_o     (ticks_left)
  );

  // Receiver. A requested hold-off keeps ready low until its countdown from
  // HoldCycles runs out, so the output register fills and the block has to stall its
  // input; otherwise ready is dropped at random at the current stall rate.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one tick word and returns at the edge that accepts it. Valid is
  // left high so that a following word can go out back to back; it only
  // drops when the sender decides to idle or stops sending words.
  task automatic send_tick(input logic press);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i   <= 1'b1;
    mode_press_i <= press;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Durations may only change while the block is idle, so the sender first
  // waits until every result word is back, then writes all three registers.
  task automatic set_durations(input logic [SecW-1:0] red, input logic [SecW-1:0] green,
                               input logic [SecW-1:0] yellow);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainSlack) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RED;
    cfg_data_i <= red;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GREEN;
    cfg_data_i <= green;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_YELLOW;
    cfg_data_i <= yellow;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned     seg;
    int unsigned     n;
    int unsigned     lead;
    logic [SecW-1:0] r;
    logic [SecW-1:0] g;
    logic [SecW-1:0] y;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The very first tick carries a press, which the init
    // tick must ignore; a few more ticks run under the reset durations.
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    // Zero durations end every phase after one tick, so the sequencer walks
    // through all four lamp pairs and loads zero counts.
    set_durations(7'd0, 7'd0, 7'd0);
    repeat (8) send_tick(1'b0);
    // A red time above 99 must load as 99 into whichever side turns red.
    set_durations(7'd127, 7'd0, 7'd0);
    repeat (6) send_tick(1'b0);

    // Random part. Any press here would lock the block in manual mode for
    // the rest of the run, so these ticks carry none; presses are saved for
    // the final stretch. Durations are a mix of extremes and random values.
    for (seg = 0; seg < SegmentCount; seg++) begin
      case (seg)
        0: begin
          r = 7'd1;
          g = 7'd1;
          y = 7'd1;
        end
        1: begin
          r = 7'd99;
          g = 7'd1;
          y = 7'd0;
        end
        2: begin
          // A zero red time keeps the red side pinned at zero, which
          // exercises the saturating countdown.
          r = 7'd0;
          g = 7'd2;
          y = 7'd1;
        end
        4: begin
          r = 7'd5;
          g = 7'd3;
          y = 7'd2;
        end
        5: begin
          r = 7'd127;
          g = 7'd1;
          y = 7'd0;
        end
        default: begin
          r = SecW'($urandom_range(127));
          g = SecW'($urandom_range(2));
          y = SecW'($urandom_range(1));
        end
      endcase
      set_durations(r, g, y);
      case (seg % 4)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 54;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 54;
        end
        default: begin
          gap_pct = 6;
          stall_pct <= 6;
        end
      endcase
      // In the segments with neither idling nor stalls the receiver holds off for a while
      // as the sender keeps pushing.
      if (seg % 4 == 0) hold_requests <= hold_requests + 1;
      repeat (RandomItems / SegmentCount) send_tick(1'b0);
    end

    // Final stretch. With short phases set and the block drained, the
    // checker's phase countdown tells how many ticks remain, so the press
    // can be placed exactly on the tick that changes phase.
    set_durations(7'd7, 7'd1, 7'd1);
    gap_pct = 0;
    stall_pct <= 0;
    repeat (DrainSlack) @(posedge clk_i);
    lead = ticks_left;
    repeat ((lead > 1) ? lead - 1 : 0) send_tick(1'b0);
    send_tick(1'b1);
    // Manual mode holds: lamps stay off, counters hold, scanning goes on,
    // whatever the button does.
    gap_pct = 6;
    stall_pct <= 6;
    repeat (ManualItems) send_tick(1'($urandom_range(1)));
    in_valid_i <= 1'b0;

    for (n = 0; n < EndWaitLimit && pending != 0; n++) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
    if (pending != 0) $error("%0d result words never arrived", pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // This bound lies far beyond the length of the whole run.
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/twtls_pkg.sv
rtl/twtls_core.sv
rtl/twtls_skid.sv
rtl/two_way_traffic_light_sequencer.sv
test/traffic_light_checker.sv
test/tb.sv
